// File: src/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Types, character codes and the case-folding compare for the wildcard
// pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_SUBJECT = 2'd2,
    ACT_FINISH  = 2'd3
  } wpm_action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_STEP,
    ST_LAND,
    ST_END,
    ST_OUT
  } wpm_state_t;

  // requests from the sequencer to the pattern store
  typedef struct packed {
    logic clear;
    logic append;
    logic rd_en;
  } wpm_store_cmd_t;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  function automatic logic char_eq(input logic [7:0] c, input logic [7:0] pc);
    logic eq;
    eq = (c == pc);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z && (c - CASE_OFFSET) == pc) begin
      eq = 1'b1;
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z && (c + CASE_OFFSET) == pc) begin
      eq = 1'b1;
    end
    return eq;
  endfunction

endpackage

// File: src/wpm_in_if.sv
// ----------------------------------------------------------------------------
// wpm_in_if
// Input channel of the matcher: action code and character.
// ----------------------------------------------------------------------------
interface wpm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] ch;

  modport source (output valid, output action, output ch, input ready);
  modport sink   (input valid, input action, input ch, output ready);
endinterface

// File: src/wpm_out_if.sv
// ----------------------------------------------------------------------------
// wpm_out_if
// Result channel of the matcher: match flag and truncation flag.
// ----------------------------------------------------------------------------
interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_truncated;

  modport source (output valid, output matched, output pattern_truncated, input ready);
  modport sink   (input valid, input matched, input pattern_truncated, output ready);
endinterface

// File: src/wpm_pattern_store.sv
// ----------------------------------------------------------------------------
// wpm_pattern_store
// Pattern memory with one write port and two registered read ports.
// Reads at or past the pattern length return the end-of-pattern code.
// ----------------------------------------------------------------------------
module wpm_pattern_store
  import wpm_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  wpm_store_cmd_t                        cmd,
  input  logic [7:0]                            wr_ch,
  input  logic [$clog2(PATTERN_MAX+2)-1:0]      rd_addr_a,
  input  logic [$clog2(PATTERN_MAX+2)-1:0]      rd_addr_b,
  output logic [7:0]                            rd_data_a,
  output logic [7:0]                            rd_data_b,
  output logic [$clog2(PATTERN_MAX+1)-1:0]      length,
  output logic                                  overflow
);

  localparam int AW = $clog2(PATTERN_MAX);
  localparam int PW = $clog2(PATTERN_MAX+2);
  localparam int LW = $clog2(PATTERN_MAX+1);

  logic [7:0] mem [PATTERN_MAX];
  logic [7:0] data_a;
  logic [7:0] data_b;
  logic       past_a;
  logic       past_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (cmd.clear) begin
      length   <= '0;
      overflow <= 1'b0;
    end else if (cmd.append) begin
      if (length < LW'(PATTERN_MAX)) begin
        length <= length + LW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !cmd.clear && length < LW'(PATTERN_MAX)) begin
      mem[length[AW-1:0]] <= wr_ch;
    end
  end

  // data registers hold their value while no read is issued
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      data_a <= mem[rd_addr_a[AW-1:0]];
      data_b <= mem[rd_addr_b[AW-1:0]];
      past_a <= (rd_addr_a >= PW'(length));
      past_b <= (rd_addr_b >= PW'(length));
    end
  end

  assign rd_data_a = past_a ? CH_NUL : data_a;
  assign rd_data_b = past_b ? CH_NUL : data_b;

endmodule

// File: src/wildcard_pattern_matcher_unit.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit
// Glob matcher with '*' and '?' and case-insensitive letters, single pattern
// pointer, no backtracking into the subject.
// ----------------------------------------------------------------------------
// clear and append items are handled in the idle state; a subject char goes through
// steps (read pointer pair, read landing position, update), without the landing read
// on a final star and with no steps once decided; the first char or end item of a
// string first skips repeated leading stars; end of subject skips trailing stars unless
// decided, and waits while the previous result is still held on the result channel
// reset clears pointers, length and flags; the pattern memory is not cleared
module wildcard_pattern_matcher_unit
  import wpm_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic     clk,
  input  logic     rst,
  wpm_in_if.sink   req,
  wpm_out_if.source rsp
);

  localparam int PW = $clog2(PATTERN_MAX+2);
  localparam int LW = $clog2(PATTERN_MAX+1);

  wpm_state_t     state, state_next;
  logic [PW-1:0]  pos, pos_next;
  logic [PW-1:0]  last_star, last_star_next;
  logic [PW-1:0]  new_pos, new_pos_next;
  logic           adv2_star, adv2_star_next;
  logic           active, active_next;
  logic           decided, decided_next;
  logic           is_end, is_end_next;
  logic [7:0]     subj_ch, subj_ch_next;
  logic           match, match_next;
  logic           out_valid, out_valid_next;
  logic           out_matched, out_matched_next;
  logic           out_trunc, out_trunc_next;

  wpm_store_cmd_t cmd;
  logic [PW-1:0]  rd_addr_a, rd_addr_b;
  logic [7:0]     d0, d1;
  logic [LW-1:0]  length;
  logic           overflow;
  logic           in_fire;
  logic           slot_free;
  logic           start_dec;

  wpm_pattern_store #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_ch     (req.ch),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (d0),
    .rd_data_b (d1),
    .length    (length),
    .overflow  (overflow)
  );

  assign req.ready             = (state == ST_IDLE);
  assign in_fire               = req.valid && req.ready;
  assign slot_free             = !out_valid || rsp.ready;
  assign rsp.valid             = out_valid;
  assign rsp.matched           = out_matched;
  assign rsp.pattern_truncated = out_trunc;
  assign start_dec             = (d0 == CH_STAR) && (d1 == CH_NUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      last_star <= '0;
      active    <= 1'b0;
      decided   <= 1'b0;
      is_end    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      last_star <= last_star_next;
      active    <= active_next;
      decided   <= decided_next;
      is_end    <= is_end_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    new_pos     <= new_pos_next;
    adv2_star   <= adv2_star_next;
    subj_ch     <= subj_ch_next;
    match       <= match_next;
    out_matched <= out_matched_next;
    out_trunc   <= out_trunc_next;
  end

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    last_star_next   = last_star;
    new_pos_next     = new_pos;
    adv2_star_next   = adv2_star;
    active_next      = active;
    decided_next     = decided;
    is_end_next      = is_end;
    subj_ch_next     = subj_ch;
    match_next       = match;
    out_valid_next   = out_valid && !rsp.ready;
    out_matched_next = out_matched;
    out_trunc_next   = out_trunc;
    cmd              = '0;
    rd_addr_a        = pos;
    rd_addr_b        = pos + PW'(1);

    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (wpm_action_t'(req.action))
            ACT_CLEAR: begin
              cmd.clear      = 1'b1;
              active_next    = 1'b0;
              decided_next   = 1'b0;
              pos_next       = '0;
              last_star_next = '0;
            end
            ACT_APPEND: begin
              if (req.ch != CH_NUL) begin
                cmd.append     = 1'b1;
                active_next    = 1'b0;
                decided_next   = 1'b0;
                pos_next       = '0;
                last_star_next = '0;
              end
            end
            ACT_SUBJECT: begin
              if (req.ch != CH_NUL) begin
                subj_ch_next = req.ch;
                is_end_next  = 1'b0;
                if (!active) begin
                  pos_next   = '0;
                  rd_addr_a  = '0;
                  rd_addr_b  = PW'(1);
                  cmd.rd_en  = 1'b1;
                  state_next = ST_START;
                end else if (!decided) begin
                  cmd.rd_en  = 1'b1;
                  state_next = ST_STEP;
                end
              end
            end
            ACT_FINISH: begin
              is_end_next = 1'b1;
              if (!active) begin
                pos_next   = '0;
                rd_addr_a  = '0;
                rd_addr_b  = PW'(1);
                cmd.rd_en  = 1'b1;
                state_next = ST_START;
              end else if (decided) begin
                match_next = 1'b1;
                state_next = ST_OUT;
              end else begin
                cmd.rd_en  = 1'b1;
                state_next = ST_END;
              end
            end
            default: ;
          endcase
        end
      end

      // skip repeated leading stars, one position a cycle
      ST_START: begin
        if (d0 == CH_STAR && d1 == CH_STAR) begin
          pos_next  = pos + PW'(1);
          rd_addr_a = pos + PW'(1);
          rd_addr_b = pos + PW'(2);
          cmd.rd_en = 1'b1;
        end else begin
          decided_next   = start_dec;
          last_star_next = pos;
          active_next    = 1'b1;
          if (is_end) begin
            if (start_dec) begin
              match_next = 1'b1;
              state_next = ST_OUT;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = ST_END;
            end
          end else if (start_dec) begin
            state_next = ST_IDLE;
          end else begin
            // d0/d1 already hold the pair at pos
            state_next = ST_STEP;
          end
        end
      end

      // d0 = pattern at pos, d1 = pattern at pos + 1
      ST_STEP: begin
        adv2_star_next = 1'b0;
        if (d0 == CH_STAR) begin
          if (d1 == CH_NUL) begin
            decided_next = 1'b1;
          end else if (char_eq(subj_ch, d1)) begin
            new_pos_next   = pos + PW'(2);
            adv2_star_next = (d1 == CH_STAR);
          end else begin
            new_pos_next = pos;
          end
        end else if (d0 == CH_QMARK) begin
          new_pos_next = pos + PW'(1);
        end else if (d0 != CH_NUL && char_eq(subj_ch, d0)) begin
          new_pos_next = pos + PW'(1);
        end else begin
          // fall back to the nearest star at or before pos, or the start position
          new_pos_next = last_star;
        end
        if (d0 == CH_STAR && d1 == CH_NUL) begin
          state_next = ST_IDLE;
        end else begin
          rd_addr_a  = new_pos_next;
          cmd.rd_en  = 1'b1;
          state_next = ST_LAND;
        end
      end

      // d0 = pattern at the landing position
      ST_LAND: begin
        decided_next = (d0 == CH_NUL);
        pos_next     = new_pos;
        if (d0 == CH_STAR) begin
          last_star_next = new_pos;
        end else if (adv2_star) begin
          last_star_next = pos + PW'(1);
        end
        state_next = ST_IDLE;
      end

      // skip trailing stars, then the end of the pattern must follow
      ST_END: begin
        if (d0 == CH_STAR) begin
          pos_next  = pos + PW'(1);
          rd_addr_a = pos + PW'(1);
          cmd.rd_en = 1'b1;
        end else begin
          match_next = (d0 == CH_NUL);
          state_next = ST_OUT;
        end
      end

      ST_OUT: begin
        if (slot_free) begin
          out_valid_next   = 1'b1;
          out_matched_next = match;
          out_trunc_next   = overflow;
          active_next      = 1'b0;
          decided_next     = 1'b0;
          pos_next         = '0;
          last_star_next   = '0;
          state_next       = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // the pointer never runs past the stored pattern
  a_pos_in_pattern: assert property (@(posedge clk) disable iff (rst)
    PW'(length) >= pos)
    else $error("pattern pointer beyond pattern length");

  // the fallback star never lies ahead of the pointer
  a_star_behind_pos: assert property (@(posedge clk) disable iff (rst)
    last_star <= pos)
    else $error("fallback star ahead of pattern pointer");

  // a result only appears after the end-of-subject handling
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result raised outside end-of-subject handling");

  // a clear item empties the pattern on the next cycle
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_fire && req.action == ACT_CLEAR) |=> (length == '0 && !overflow && !active))
    else $error("clear item did not empty the pattern");

endmodule

// File: bench/wpm_match_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wpm_match_checker
// Watches the request and result channels of the wildcard matcher, keeps its
// own model of the pattern and pointer state, predicts the match answer for
// every end-of-subject item and compares each result against it in order.
// ----------------------------------------------------------------------------
module wpm_match_checker
  import wpm_pkg::*;
#(
  parameter int PATTERN_MAX = 64
) (
  input  logic clk,
  input  logic rst,
  wpm_in_if    req,
  wpm_out_if   rsp,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic matched;
    logic truncated;
  } match_result_t;

  logic [7:0]    pat_mem [PATTERN_MAX];
  int            pat_len;
  int            pat_ptr;
  logic          in_subject;
  logic          settled_match;
  logic          overflowed;
  match_result_t answer_q [$];

  function automatic logic [7:0] pat_char(input int i);
    if (i < pat_len) begin
      return pat_mem[i];
    end
    return CH_NUL;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic same_letter(input logic [7:0] c, input logic [7:0] pc);
    return fold_case(c) == fold_case(pc);
  endfunction

  function automatic void drop_subject();
    in_subject    = 1'b0;
    settled_match = 1'b0;
    pat_ptr       = 0;
  endfunction

  // skip a run of leading stars down to its last one
  function automatic void begin_string();
    int p;
    p = 0;
    while (pat_char(p) == CH_STAR && pat_char(p + 1) == CH_STAR) begin
      p++;
    end
    settled_match = (pat_char(p) == CH_STAR) && (pat_char(p + 1) == CH_NUL);
    pat_ptr       = p;
    in_subject    = 1'b1;
  endfunction

  function automatic void feed_char(input logic [7:0] c);
    int p;
    if (!in_subject) begin
      begin_string();
    end
    if (settled_match) begin
      return;
    end
    p = pat_ptr;
    if (pat_char(p) == CH_STAR) begin
      if (pat_char(p + 1) == CH_NUL) begin
        settled_match = 1'b1;
        return;
      end
      if (same_letter(c, pat_char(p + 1))) begin
        p += 2;
      end
    end else if (pat_char(p) == CH_QMARK) begin
      p++;
    end else if (pat_char(p) != CH_NUL && same_letter(c, pat_char(p))) begin
      p++;
    end else begin
      // fall back to the nearest star, or the start
      while (p != 0 && pat_char(p) != CH_STAR) begin
        p--;
      end
    end
    if (pat_char(p) == CH_NUL) begin
      settled_match = 1'b1;
    end
    pat_ptr = p;
  endfunction

  function automatic void apply_item(input logic [1:0] act, input logic [7:0] c);
    match_result_t ans;
    int            p;
    case (wpm_action_t'(act))
      ACT_CLEAR: begin
        pat_len    = 0;
        overflowed = 1'b0;
        drop_subject();
      end
      ACT_APPEND: begin
        if (c != CH_NUL) begin
          drop_subject();
          if (pat_len < PATTERN_MAX) begin
            pat_mem[pat_len] = c;
            pat_len++;
          end else begin
            overflowed = 1'b1;
          end
        end
      end
      ACT_SUBJECT: begin
        if (c != CH_NUL) begin
          feed_char(c);
        end
      end
      default: begin
        if (!in_subject) begin
          begin_string();
        end
        if (settled_match) begin
          ans.matched = 1'b1;
        end else begin
          p = pat_ptr;
          while (pat_char(p) == CH_STAR) begin
            p++;
          end
          ans.matched = (pat_char(p) == CH_NUL);
        end
        ans.truncated = overflowed;
        answer_q.push_back(ans);
        drop_subject();
      end
    endcase
  endfunction

  always @(posedge clk) begin
    match_result_t want;
    if (rst) begin
      pat_len    = 0;
      overflowed = 1'b0;
      drop_subject();
      answer_q.delete();
      fail_count = 0;
    end else begin
      // results first so an item accepted on the same edge cannot pair with one
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result matched=%0b truncated=%0b",
                   $time, rsp.matched, rsp.pattern_truncated);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (rsp.matched !== want.matched ||
              rsp.pattern_truncated !== want.truncated) begin
            $display("%0t: expected matched=%0b trunc=%0b, got matched=%0b trunc=%0b",
                     $time, want.matched, want.truncated,
                     rsp.matched, rsp.pattern_truncated);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        apply_item(req.action, req.ch);
      end
    end
    pending = answer_q.size();
  end

endmodule

// File: bench/wildcard_pattern_matcher_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_unit_tb
// Drives pattern loads and subject strings into the wildcard matcher: a short
// directed list, then random patterns with mostly well-formed subjects under
// three idling regimes. A checker beside the block predicts every answer.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_unit_tb
  import wpm_pkg::*;
();

  localparam int PAT_MAX      = 64;
  localparam int RANDOM_ITEMS = 1400;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 600000;

  logic       clk;
  logic       rst;
  int         fail_count;
  int         pending;
  int         cycle_cnt;
  int         item_cnt;
  int         src_idle_pct;
  int         snk_idle_pct;
  logic [7:0] pat_buf [$];

  wpm_in_if  req ();
  wpm_out_if rsp ();

  wildcard_pattern_matcher_unit #(.PATTERN_MAX(PAT_MAX)) dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  wpm_match_checker #(.PATTERN_MAX(PAT_MAX)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp.ready = ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_item(input wpm_action_t act, input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid  = 1'b1;
    req.action = act;
    req.ch     = c;
    @(posedge clk);
    while (!req.ready) begin
      @(posedge clk);
    end
    item_cnt++;
  endtask

  function automatic logic [7:0] any_letter();
    logic [7:0] c;
    c = CH_LOWER_A + 8'($urandom_range(2));
    if ($urandom_range(1)) begin
      c = c - CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_pat_char();
    int r;
    r = $urandom_range(99);
    if (r < 20) begin
      return CH_STAR;
    end else if (r < 35) begin
      return CH_QMARK;
    end else if (r < 90) begin
      return any_letter();
    end
    return 8'($urandom_range(255, 1));
  endfunction

  task automatic load_pattern(input int len);
    logic [7:0] c;
    send_item(ACT_CLEAR, 8'($urandom_range(255)));
    pat_buf.delete();
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 3) begin
        send_item(ACT_APPEND, CH_NUL);
      end
      c = pick_pat_char();
      send_item(ACT_APPEND, c);
      if (pat_buf.size() < PAT_MAX) begin
        pat_buf.push_back(c);
      end
    end
  endtask

  task automatic run_subject();
    logic [7:0] subj [$];
    logic [7:0] c;
    int         n;
    if ($urandom_range(99) < 70) begin
      // follow the pattern so the pointer gets deep into it
      foreach (pat_buf[i]) begin
        c = pat_buf[i];
        if (c == CH_STAR) begin
          n = $urandom_range(3);
          for (int k = 0; k < n; k++) begin
            subj.push_back(any_letter());
          end
        end else if (c == CH_QMARK) begin
          subj.push_back(any_letter());
        end else begin
          if (((c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z)) && $urandom_range(1)) begin
            c = c ^ CASE_OFFSET;
          end
          subj.push_back(c);
        end
      end
      if (subj.size() > 0 && $urandom_range(99) < 25) begin
        subj[$urandom_range(subj.size() - 1)] = any_letter();
      end
      if ($urandom_range(99) < 15) begin
        subj.push_back(any_letter());
      end
    end else begin
      n = $urandom_range(8);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99) < 15) begin
          subj.push_back(8'($urandom_range(255, 1)));
        end else begin
          subj.push_back(any_letter());
        end
      end
    end
    foreach (subj[i]) begin
      if ($urandom_range(99) < 4) begin
        send_item(ACT_SUBJECT, CH_NUL);
      end
      send_item(ACT_SUBJECT, subj[i]);
    end
    send_item(ACT_FINISH, 8'($urandom_range(255)));
  endtask

  // raw items: clears and appends in the middle of a subject, stray finishes
  task automatic run_noise();
    int         n;
    logic [1:0] act;
    logic [7:0] c;
    n = $urandom_range(4, 1);
    for (int k = 0; k < n; k++) begin
      act = 2'($urandom_range(3));
      c   = 8'($urandom_range(255));
      send_item(wpm_action_t'(act), c);
      if (act == ACT_CLEAR) begin
        pat_buf.delete();
      end else if (act == ACT_APPEND && c != CH_NUL && pat_buf.size() < PAT_MAX) begin
        pat_buf.push_back(c);
      end
    end
  endtask

  task automatic run_phase(input int count);
    int stop_at;
    int r;
    stop_at = item_cnt + count;
    load_pattern($urandom_range(6, 1));
    while (item_cnt < stop_at) begin
      r = $urandom_range(99);
      if (r < 15) begin
        r = $urandom_range(99);
        if (r < 85) begin
          load_pattern($urandom_range(8));
        end else if (r < 95) begin
          load_pattern($urandom_range(20, 9));
        end else begin
          load_pattern($urandom_range(PAT_MAX + 6, PAT_MAX - 4));
        end
      end else if (r < 90) begin
        run_subject();
      end else begin
        run_noise();
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    req.valid    = 1'b0;
    req.action   = ACT_CLEAR;
    req.ch       = CH_NUL;
    rsp.ready    = 1'b0;
    cycle_cnt    = 0;
    item_cnt     = 0;
    src_idle_pct = 22;
    snk_idle_pct = 80;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty pattern against an empty and a one-char subject
    send_item(ACT_FINISH, CH_NUL);
    send_item(ACT_SUBJECT, 8'hFF);
    send_item(ACT_FINISH, 8'hFF);
    // zero append is dropped, a lone star run matches at once
    send_item(ACT_APPEND, CH_NUL);
    send_item(ACT_APPEND, CH_STAR);
    send_item(ACT_APPEND, CH_STAR);
    send_item(ACT_FINISH, CH_NUL);
    send_item(ACT_SUBJECT, "q");
    send_item(ACT_FINISH, CH_NUL);
    // case folding, question mark, ignored zero subject char
    send_item(ACT_CLEAR, 8'hFF);
    send_item(ACT_APPEND, "A");
    send_item(ACT_APPEND, CH_QMARK);
    send_item(ACT_APPEND, "c");
    send_item(ACT_SUBJECT, "a");
    send_item(ACT_SUBJECT, "Z");
    send_item(ACT_SUBJECT, CH_NUL);
    send_item(ACT_SUBJECT, "C");
    send_item(ACT_FINISH, CH_NUL);
    // append in the middle of a subject abandons it
    send_item(ACT_SUBJECT, "a");
    send_item(ACT_APPEND, CH_STAR);
    send_item(ACT_SUBJECT, "a");
    send_item(ACT_SUBJECT, "b");
    send_item(ACT_FINISH, CH_NUL);
    send_item(ACT_CLEAR, CH_NUL);
    send_item(ACT_FINISH, CH_NUL);

    // overfilled pattern first, then random traffic
    load_pattern(PAT_MAX + 3);
    run_subject();
    run_phase(RANDOM_ITEMS / 3);
    src_idle_pct = 80;
    snk_idle_pct = 22;
    run_phase(RANDOM_ITEMS / 3);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(RANDOM_ITEMS / 3);

    @(negedge clk);
    req.valid = 1'b0;
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
